// File: rtl/aba_pkg.sv
// Shared types and constants for the ADC block averager.
package aba_pkg;

  localparam int SampleW    = 12;
  localparam int SumW       = 20;
  localparam int CountW     = 8;
  localparam int LevelW     = 12;
  localparam int RemW       = 5;
  localparam int BatteryW   = 16;
  localparam int EmaShift   = 5;

  localparam int FullScaleMv  = 3300;
  localparam int AdcMaxCode   = 4095;
  localparam int BatteryRatio = 11;

  // Reciprocal of the ADC full-scale code, used to divide the scaled product.
  localparam int ScaleShift = 36;
  localparam int ScaleRecipW = 25;
  localparam logic [ScaleRecipW-1:0] ScaleRecip =
    ScaleRecipW'((64'd1 << ScaleShift) / AdcMaxCode);

  localparam int QueueDepth = 4;
  localparam int QueueIdxW  = $clog2(QueueDepth);

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [SumW-1:0]    sum_t;
  typedef logic [LevelW-1:0]  level_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// File: rtl/aba_front.sv
// Front end: accumulates samples and hands each finished block sum to the queue.
module aba_front #(
  parameter int SAMPLES_PER_BLOCK = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            queue_full,
  input  aba_pkg::sample_t sample,
  output logic            push,
  output aba_pkg::sum_t   push_sum
);
  import aba_pkg::*;

  localparam logic [CountW-1:0] LastCount = CountW'(SAMPLES_PER_BLOCK - 1);

  logic [CountW-1:0] block_count;
  sum_t              block_sum;
  sum_t              sum_next;
  logic              accept;
  logic              last;

  assign accept   = in_valid && !queue_full;
  assign last     = (block_count == LastCount);
  assign sum_next = block_sum + SumW'(sample);
  assign push     = accept && last;
  assign push_sum = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      block_sum   <= '0;
    end else if (accept) begin
      if (last) begin
        block_count <= '0;
        block_sum   <= '0;
      end else begin
        block_count <= block_count + 1'b1;
        block_sum   <= sum_next;
      end
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    block_count <= LastCount)
    else $error("block count ran past the block length");

endmodule

// File: rtl/aba_fifo.sv
// Short queue of block sums between the front end and the arithmetic pipeline.
module aba_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  aba_pkg::sum_t         push_sum,
  input  logic                  pop,
  output aba_pkg::sum_t         pop_sum,
  output aba_pkg::queue_status_t status
);
  import aba_pkg::*;

  sum_t                 entries [QueueDepth];
  logic [QueueIdxW-1:0] wr_ptr;
  logic [QueueIdxW-1:0] rd_ptr;
  logic [QueueIdxW:0]   fill;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == (QueueIdxW+1)'(QueueDepth));
  assign pop_sum      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("block sum pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("block sum popped from an empty queue");

endmodule

// File: rtl/aba_back.sv
// Back end: block mean, millivolt scaling, moving-average update, battery voltage and output register.
module aba_back #(
  parameter int SAMPLES_PER_BLOCK = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  aba_pkg::queue_status_t queue_status,
  input  aba_pkg::sum_t          queue_sum,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output aba_pkg::level_t        mean_mv,
  output logic [aba_pkg::BatteryW-1:0] battery_mv
);
  import aba_pkg::*;

  // The block mean is taken as a reciprocal multiply that may come out one low,
  // then fixed with one compare against the block length.
  localparam int DivShift  = 31;
  localparam int DivRecipW = 32;
  localparam logic [DivRecipW-1:0] DivRecip =
    DivRecipW'((64'd1 << DivShift) / SAMPLES_PER_BLOCK);
  localparam int BlockLenW = 9;
  localparam logic [BlockLenW-1:0] BlockLen = BlockLenW'(SAMPLES_PER_BLOCK);
  localparam int DivProdW  = SumW + DivRecipW;
  localparam int QnW       = SumW + BlockLenW;
  localparam int ScaledW   = 24;
  localparam int ScaleProdW = ScaledW + ScaleRecipW;
  localparam int TotalW    = LevelW + EmaShift;

  logic       advance;
  logic [4:0] stage_valid;

  // Stage 1: estimated quotient.
  sum_t                s1_sum;
  sum_t                s1_quot;
  logic [DivProdW-1:0] div_prod;
  // Stage 2: exact block mean.
  level_t              s2_mean;
  logic [QnW-1:0]      div_back;
  logic [QnW-1:0]      div_rem;
  sum_t                quot_fixed;
  // Stage 3: mean times full-scale millivolts.
  logic [ScaledW-1:0]  s3_prod;
  // Stage 4: estimated scaled value.
  logic [ScaledW-1:0]  s4_prod;
  level_t              s4_quot;
  logic [ScaleProdW-1:0] scale_prod;
  // Stage 5: exact scaled value.
  level_t              s5_scaled;
  logic [ScaledW-1:0]  scale_back;
  logic [ScaledW-1:0]  scale_rem;
  level_t              scaled_fixed;
  // Output stage: moving-average state.
  logic [RemW-1:0]     carry_remainder;
  logic [TotalW-1:0]   total;
  level_t              level_next;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !queue_status.empty;

  always_comb begin
    div_prod   = DivProdW'(queue_sum) * DivProdW'(DivRecip);
    div_back   = QnW'(s1_quot) * QnW'(BlockLen);
    div_rem    = QnW'(s1_sum) - div_back;
    quot_fixed = (div_rem >= QnW'(BlockLen)) ? s1_quot + 1'b1 : s1_quot;
    scale_prod = ScaleProdW'(s3_prod) * ScaleProdW'(ScaleRecip);
    scale_back = ScaledW'(s4_quot) * ScaledW'(AdcMaxCode);
    scale_rem  = s4_prod - scale_back;
    scaled_fixed = (scale_rem >= ScaledW'(AdcMaxCode)) ? s4_quot + 1'b1 : s4_quot;
    total = TotalW'(s5_scaled)
          + ((TotalW'(mean_mv) << EmaShift) - TotalW'(mean_mv))
          + TotalW'(carry_remainder);
    level_next = total[TotalW-1:EmaShift];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sum    <= queue_sum;
      s1_quot   <= div_prod[DivShift +: SumW];
      s2_mean   <= quot_fixed[LevelW-1:0];
      s3_prod   <= ScaledW'(s2_mean) * ScaledW'(FullScaleMv);
      s4_prod   <= s3_prod;
      s4_quot   <= scale_prod[ScaleShift +: LevelW];
      s5_scaled <= scaled_fixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid     <= '0;
      out_valid       <= 1'b0;
      mean_mv         <= '0;
      carry_remainder <= '0;
      battery_mv      <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[3:0], !queue_status.empty};
      out_valid   <= stage_valid[4];
      if (stage_valid[4]) begin
        mean_mv         <= level_next;
        carry_remainder <= total[RemW-1:0];
        battery_mv      <= BatteryW'(level_next) * BatteryW'(BatteryRatio);
      end
    end
  end

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    mean_mv <= level_t'(FullScaleMv))
    else $error("smoothed level exceeds full scale");

  a_battery_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> battery_mv == BatteryW'(mean_mv) * BatteryW'(BatteryRatio))
    else $error("battery voltage does not match the smoothed level");

endmodule

// File: rtl/adc_block_average_ema.sv
// Top level of the ADC block averager with a 1/32 moving average.
// Accepts one 12-bit sample per clock while the four-entry block-sum queue
// has room; every SAMPLES_PER_BLOCK samples a block sum is queued and, once it
// has passed the queue, the arithmetic stages and the output register, the
// smoothed level in mV and the battery voltage (level times eleven) appear on
// the output. The arithmetic pipeline takes one block sum per cycle while the
// output is not stalled, so the output rate is set only by the block length
// and by output-side stalls, which the queue absorbs before the input stalls.
module adc_block_average_ema #(
  parameter int SAMPLES_PER_BLOCK = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  aba_pkg::sample_t              sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output aba_pkg::level_t               mean_mv,
  output logic [aba_pkg::BatteryW-1:0]  battery_mv
);
  import aba_pkg::*;

  logic          push;
  sum_t          push_sum;
  logic          pop;
  sum_t          pop_sum;
  queue_status_t queue_status;

  assign in_stall = queue_status.full;

  aba_front #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .queue_full(queue_status.full),
    .sample    (sample),
    .push      (push),
    .push_sum  (push_sum)
  );

  aba_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_sum(push_sum),
    .pop     (pop),
    .pop_sum (pop_sum),
    .status  (queue_status)
  );

  aba_back #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_status(queue_status),
    .queue_sum   (pop_sum),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mean_mv     (mean_mv),
    .battery_mv  (battery_mv)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the ADC block averager with its 1/32 moving average.
module testbench;
  import aba_pkg::*;

  localparam int Spb = 8;
  localparam int RandomItems = 1925;
  localparam int HoldCycles = 500;
  localparam int StallLimit = 2000;

  typedef struct packed {
    level_t                mv;
    logic [BatteryW-1:0]   batt;
  } reading_t;

  // Directed rows carry a typed-in reading only where it is plain to see.
  typedef struct packed {
    sample_t               s;
    logic                  typed;
    level_t                mv;
    logic [BatteryW-1:0]   batt;
  } row_t;

  typedef enum {FullScale, Ground, AnyCode, NearTop, NearBottom} level_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  level_t mean_mv;
  logic [BatteryW-1:0] battery_mv;

  adc_block_average_ema #(.SAMPLES_PER_BLOCK(Spb)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_mv    (mean_mv),
    .battery_mv (battery_mv)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state, mirroring the block's accumulators and average.
  logic [CountW-1:0] blk_count = '0;
  sum_t              blk_sum = '0;
  level_t            ema_level = '0;
  logic [RemW-1:0]   ema_rem = '0;

  reading_t readings_due[$];
  int mismatches = 0;
  int readings_taken = 0;
  bit holding = 1'b0;
  bit no_gaps = 1'b0;

  row_t directed_rows [0:23] = '{
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b1, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b1, 12'd103, 16'd1133},
    '{12'hAAA, 1'b0, 12'd0, 16'd0},
    '{12'h555, 1'b0, 12'd0, 16'd0},
    '{12'h001, 1'b0, 12'd0, 16'd0},
    '{12'h800, 1'b0, 12'd0, 16'd0},
    '{12'hFFF, 1'b0, 12'd0, 16'd0},
    '{12'h000, 1'b0, 12'd0, 16'd0},
    '{12'h7FF, 1'b0, 12'd0, 16'd0},
    '{12'h123, 1'b0, 12'd0, 16'd0}
  };

  // Adds one sample to the block; at the block end it updates the average.
  function automatic bit take_sample(input sample_t s, output reading_t r);
    sum_t        mean;
    logic [31:0] scaled;
    logic [31:0] total;
    r = '0;
    blk_sum = blk_sum + SumW'(s);
    if (32'(blk_count) + 1 < Spb) begin
      blk_count = blk_count + 1'b1;
      return 1'b0;
    end
    mean = blk_sum / SumW'(Spb);
    scaled = (32'(mean) * FullScaleMv) / AdcMaxCode;
    total = scaled + 32'(ema_level) * 31 + 32'(ema_rem);
    ema_level = LevelW'(total >> EmaShift);
    ema_rem = RemW'(total);
    blk_count = '0;
    blk_sum = '0;
    r.mv = ema_level;
    r.batt = BatteryW'(32'(ema_level) * BatteryRatio);
    return 1'b1;
  endfunction

  task automatic send_sample(input sample_t s, input logic typed, input level_t mv,
                             input logic [BatteryW-1:0] batt);
    int gap;
    reading_t r;
    gap = (no_gaps || holding) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (take_sample(s, r)) begin
      if (typed) begin
        r.mv = mv;
        r.batt = batt;
      end
      readings_due.push_back(r);
    end
  endtask

  // Receiver: random stall before each transaction, plus one long hold-off.
  initial begin
    int gap;
    reading_t want;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && readings_taken == 20) begin
        held = 1'b1;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holding = 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      readings_taken++;
      if (readings_due.size() == 0) begin
        $error("unexpected result: mean_mv %0d battery_mv %0d", mean_mv, battery_mv);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        if (mean_mv !== want.mv) begin
          $error("mean_mv: expected %0d, got %0d", want.mv, mean_mv);
          mismatches++;
        end
        if (battery_mv !== want.batt) begin
          $error("battery_mv: expected %0d, got %0d", want.batt, battery_mv);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if no transaction moves on either side for too long.
  initial begin
    int idle;
    idle = 0;
    @(negedge rst);
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    level_mode_t mode;
    int run_blocks;
    int sent;
    sample_t s;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].mv,
                  directed_rows[i].batt);

    // Runs of whole blocks in one input mode (fixed, near-rail or random), so the average climbs and falls.
    sent = 0;
    while (sent < RandomItems) begin
      mode = ($urandom_range(0, 2) == 0) ? FullScale : level_mode_t'($urandom_range(0, 4));
      run_blocks = $urandom_range(1, 30);
      for (int b = 0; b < run_blocks && sent < RandomItems; b++) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < Spb; k++) begin
          case (mode)
            FullScale:  s = sample_t'(AdcMaxCode);
            Ground:     s = '0;
            NearTop:    s = sample_t'($urandom_range(4000, 4095));
            NearBottom: s = sample_t'($urandom_range(0, 63));
            default:    s = sample_t'($urandom_range(0, 4095));
          endcase
          send_sample(s, 1'b0, '0, '0);
          sent++;
        end
      end
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    while (readings_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/aba_pkg.sv
rtl/aba_front.sv
rtl/aba_fifo.sv
rtl/aba_back.sv
rtl/adc_block_average_ema.sv
bench/testbench.sv
